/* hdl/obsm_pkg.sv */
// ----------------------------------------------------------------------------
// obsm_pkg
// shared types and constants for the object bounding box stability monitor
// ----------------------------------------------------------------------------
package obsm_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 64;
	localparam int unsigned COORD_BITS_DEF    = 19;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned WIN_W      = 7;
	localparam int unsigned DIST_W     = 16;
	localparam int unsigned COUNT_W    = 16;

	// twice the still distance, and the operand width of the squares
	localparam int unsigned LIM_W = DIST_W + 1;
	localparam int unsigned SQ_W  = 2 * LIM_W;
	localparam int unsigned SUM_W = SQ_W + 2;

	localparam logic [WIN_W-1:0]   WINDOW_RST   = 7'd10;
	localparam logic [DIST_W-1:0]  STILL_RST    = 16'd100;
	localparam logic [COUNT_W-1:0] MIN_PTS_RST  = 16'd50;
	localparam logic [COUNT_W-1:0] COUNT_SAT    = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW  = 2'd0,
		CFG_STILL   = 2'd1,
		CFG_MIN_PTS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_LEAVE  = 2'd0,
		ST_MOVING = 2'd1,
		ST_STABLE = 2'd2
	} status_t;

endpackage

/* hdl/object_bbox_stability_monitor.sv */
// path: a closing point's result passes the stage 1, 2 and 3 registers, then the output register
// throughput: one transaction per cycle, points and frame ends alike, no stall unless
// the output side holds back; the ring memory is read and written at most once per cycle
// reset clears the box, point count, ring head and fill, and the pipeline valids
// the centre ring memory is not cleared, the fill count masks stale entries
// ----------------------------------------------------------------------------
// object_bbox_stability_monitor
// running 3d bounding box per frame, centre history in a ring memory and a
// squared distance test against the oldest centre of the window
// ----------------------------------------------------------------------------
module object_bbox_stability_monitor #(
	parameter int unsigned HISTORY_DEPTH = obsm_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned COORD_BITS    = obsm_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [obsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [obsm_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [COORD_BITS-1:0]        x_mm,
	input  logic signed [COORD_BITS-1:0]        y_mm,
	input  logic signed [COORD_BITS-1:0]        z_mm,
	input  logic                                last,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic                                present,
	output logic signed [COORD_BITS-1:0]        min_x,
	output logic signed [COORD_BITS-1:0]        min_y,
	output logic signed [COORD_BITS-1:0]        min_z,
	output logic signed [COORD_BITS-1:0]        max_x,
	output logic signed [COORD_BITS-1:0]        max_y,
	output logic signed [COORD_BITS-1:0]        max_z,
	output logic signed [COORD_BITS:0]          centre_x2,
	output logic signed [COORD_BITS:0]          centre_y2,
	output logic signed [COORD_BITS:0]          centre_z2,
	output logic [obsm_pkg::COUNT_W-1:0]        point_count
);

	localparam int unsigned CB = COORD_BITS;
	localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned DW = (CB + 2 > obsm_pkg::LIM_W) ? CB + 2 : obsm_pkg::LIM_W;
	localparam int unsigned LW = obsm_pkg::LIM_W;

	typedef struct packed {
		logic                       present;
		logic [2:0][CB-1:0]         lo;
		logic [2:0][CB-1:0]         hi;
		logic [2:0][CB:0]           c;
		logic [obsm_pkg::COUNT_W-1:0] cnt;
	} res_t;

	// configuration
	logic [obsm_pkg::WIN_W-1:0]   window_q;
	logic [obsm_pkg::DIST_W-1:0]  still_q;
	logic [obsm_pkg::COUNT_W-1:0] min_pts_q;
	logic [LW-1:0]                lim;
	logic [obsm_pkg::SQ_W-1:0]    lim_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= obsm_pkg::WINDOW_RST;
			still_q   <= obsm_pkg::STILL_RST;
			min_pts_q <= obsm_pkg::MIN_PTS_RST;
		end else if (cfg_we) begin
			case (obsm_pkg::cfg_idx_t'(cfg_index))
				obsm_pkg::CFG_WINDOW:  window_q  <= cfg_data[obsm_pkg::WIN_W-1:0];
				obsm_pkg::CFG_STILL:   still_q   <= cfg_data[obsm_pkg::DIST_W-1:0];
				obsm_pkg::CFG_MIN_PTS: min_pts_q <= cfg_data[obsm_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign lim = {still_q, 1'b0};

	// squared limit follows the still distance register in the next cycle
	always_ff @(posedge clk) begin
		lim_sq_q <= lim * lim;
	end

	// pipeline handshake
	logic rdy_out, rdy3, rdy2, rdy1;
	logic v_s1, v_s2, v_s3;
	logic acc, acc_res, push;

	assign rdy_out  = !out_valid || out_ready;
	assign rdy3     = !v_s3 || rdy_out;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign acc      = in_valid && in_ready;
	assign acc_res  = acc && (kind || last);

	// frame accumulation
	logic [2:0][CB-1:0]           lo_q, hi_q, lo_new, hi_new, pt;
	logic [2:0][CB:0]             c_new;
	logic [obsm_pkg::COUNT_W-1:0] points_q, points_new;
	logic                         enough;

	assign pt[0] = x_mm;
	assign pt[1] = y_mm;
	assign pt[2] = z_mm;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo_new[a] = ($signed(pt[a]) < $signed(lo_q[a])) ? pt[a] : lo_q[a];
			hi_new[a] = ($signed(pt[a]) > $signed(hi_q[a])) ? pt[a] : hi_q[a];
			c_new[a]  = (CB+1)'($signed({lo_new[a][CB-1], lo_new[a]})
				+ $signed({hi_new[a][CB-1], hi_new[a]}));
		end
		points_new = (points_q == obsm_pkg::COUNT_SAT) ? points_q
			: points_q + obsm_pkg::COUNT_W'(1);
		enough = points_new >= min_pts_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= {1'b0, {(CB-1){1'b1}}};
				hi_q[a] <= {1'b1, {(CB-1){1'b0}}};
			end
			points_q <= '0;
		end else if (acc) begin
			if (kind || last) begin
				for (int a = 0; a < 3; a++) begin
					lo_q[a] <= {1'b0, {(CB-1){1'b1}}};
					hi_q[a] <= {1'b1, {(CB-1){1'b0}}};
				end
				points_q <= '0;
			end else begin
				lo_q     <= lo_new;
				hi_q     <= hi_new;
				points_q <= points_new;
			end
		end
	end

	// ring bookkeeping
	logic [AW-1:0] head_q, head_new, rd_addr;
	logic [FW-1:0] fill_q, fill_inc, fill_new, win_eff;
	logic [FW:0]   oldest_w;

	always_comb begin
		if (window_q == '0)
			win_eff = FW'(1);
		else if (32'(window_q) > HISTORY_DEPTH)
			win_eff = FW'(HISTORY_DEPTH);
		else
			win_eff = FW'(window_q);

		head_new = (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + AW'(1);
		fill_inc = (32'(fill_q) < HISTORY_DEPTH) ? fill_q + FW'(1) : fill_q;
		fill_new = (fill_inc > win_eff) ? win_eff : fill_inc;

		if ((FW+1)'(head_new) >= (FW+1)'(fill_new))
			oldest_w = (FW+1)'(head_new) - (FW+1)'(fill_new);
		else
			oldest_w = (FW+1)'(head_new) + (FW+1)'(HISTORY_DEPTH) - (FW+1)'(fill_new);
		rd_addr = oldest_w[AW-1:0];
	end

	assign push = acc && !kind && last && enough;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (acc_res) begin
			if (push) begin
				head_q <= head_new;
				fill_q <= fill_new;
			end else begin
				head_q <= '0;
				fill_q <= '0;
			end
		end
	end

	// centre ring memory
	logic [2:0][CB:0] ring_mem [HISTORY_DEPTH];
	logic [2:0][CB:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (push)
			ring_mem[head_q] <= c_new;
		if (acc)
			rdata_s1 <= ring_mem[rd_addr];
	end

	// stage 1: frame closed, oldest centre read
	res_t              r_s1, r_s2, r_s3;
	obsm_pkg::status_t st_s1, st_s2, st_s3;
	logic              cmp_s1, cmp_s2, cmp_s3;
	logic              fwd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= acc_res;
	end

	always_ff @(posedge clk) begin
		if (acc_res) begin
			if (kind) begin
				r_s1   <= '0;
				st_s1  <= obsm_pkg::ST_LEAVE;
				cmp_s1 <= 1'b0;
			end else begin
				r_s1.present <= 1'b1;
				r_s1.lo      <= lo_new;
				r_s1.hi      <= hi_new;
				r_s1.c       <= c_new;
				r_s1.cnt     <= points_new;
				st_s1        <= enough ? obsm_pkg::ST_MOVING : obsm_pkg::ST_LEAVE;
				cmp_s1       <= enough && (fill_new >= win_eff);
			end
			// window of one reads the entry written in the same cycle
			fwd_s1 <= (rd_addr == head_q);
		end
	end

	// stage 2: per axis distance to the oldest centre
	logic [2:0][CB:0]    old_c;
	logic [2:0][CB+1:0]  diff, absd;
	logic [2:0][DW-1:0]  absd_ext;
	logic [2:0]          far;
	logic                far_s2, far_s3;
	logic [2:0][LW-1:0]  d_s2;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			old_c[a]    = fwd_s1 ? r_s1.c[a] : rdata_s1[a];
			diff[a]     = (CB+2)'($signed({r_s1.c[a][CB], r_s1.c[a]})
				- $signed({old_c[a][CB], old_c[a]}));
			absd[a]     = diff[a][CB+1] ? (CB+2)'(-diff[a]) : diff[a];
			absd_ext[a] = DW'(absd[a]);
			far[a]      = absd_ext[a] >= DW'(lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			r_s2   <= r_s1;
			st_s2  <= st_s1;
			cmp_s2 <= cmp_s1;
			far_s2 <= |far;
			for (int a = 0; a < 3; a++)
				d_s2[a] <= absd_ext[a][LW-1:0];
		end
	end

	// stage 3: squares
	logic [2:0][obsm_pkg::SQ_W-1:0] sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			r_s3   <= r_s2;
			st_s3  <= st_s2;
			cmp_s3 <= cmp_s2;
			far_s3 <= far_s2;
			for (int a = 0; a < 3; a++)
				sq_s3[a] <= d_s2[a] * d_s2[a];
		end
	end

	// sum of squares against the squared limit, then the output register
	logic [obsm_pkg::SUM_W-1:0] d2;
	obsm_pkg::status_t          st_fin;

	always_comb begin
		d2 = obsm_pkg::SUM_W'(sq_s3[0]) + obsm_pkg::SUM_W'(sq_s3[1])
			+ obsm_pkg::SUM_W'(sq_s3[2]);
		if (cmp_s3)
			st_fin = (!far_s3 && d2 < obsm_pkg::SUM_W'(lim_sq_q))
				? obsm_pkg::ST_STABLE : obsm_pkg::ST_MOVING;
		else
			st_fin = st_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (rdy_out)
			out_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			status      <= st_fin;
			present     <= r_s3.present;
			min_x       <= r_s3.lo[0];
			min_y       <= r_s3.lo[1];
			min_z       <= r_s3.lo[2];
			max_x       <= r_s3.hi[0];
			max_y       <= r_s3.hi[1];
			max_z       <= r_s3.hi[2];
			centre_x2   <= r_s3.c[0];
			centre_y2   <= r_s3.c[1];
			centre_z2   <= r_s3.c[2];
			point_count <= r_s3.cnt;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= HISTORY_DEPTH)
		else $error("ring fill beyond history depth");

	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind) |=> (fill_q == '0 && head_q == '0 && points_q == '0))
		else $error("empty frame did not clear history");

	a_absent_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !present) |-> (status == obsm_pkg::ST_LEAVE))
		else $error("absent object not reported as leave");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (v_s1 && st_s1 == obsm_pkg::ST_MOVING))
		else $error("centre pushed without a pending result");

endmodule
